// ----- design/dgb_pkg.sv -----
// Shared types, constants and control word layout for the decimal digit blinker.
// No dependencies; imported by every module of the block.
`default_nettype none

package dgb_pkg;

  // Readout geometry
  localparam int MAX_DIGITS = 5;
  localparam int PTR_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // Field widths
  localparam int NUM_W     = 16;
  localparam int DIGIT_W   = 4;
  localparam int BLINK_W   = 4;
  localparam int TICK_W    = 8;
  localparam int LEVEL_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Divide by ten: q = (n * 52429) >> 19 is exact for every 16-bit n
  localparam int                 RECIP_W     = NUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP_10    = 17'd52429;
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [TICK_W-1:0] ZERO_BLINK_TICKS = 8'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] ON_TICKS_RST    = 8'd10;
  localparam logic [CFG_W-1:0] OFF_TICKS_RST   = 8'd30;
  localparam logic [CFG_W-1:0] SPACE_TICKS_RST = 8'd60;
  localparam logic [CFG_W-1:0] BRIGHTNESS_RST  = 8'd64;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ON,
    PH_OFF,
    PH_SPACE
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_TICKS,
    CFG_OFF_TICKS,
    CFG_SPACE_TICKS,
    CFG_BRIGHTNESS
  } cfg_idx_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_TICK,
    OP_CONV_INIT,
    OP_DIV,
    OP_REM,
    OP_LOAD,
    OP_NEXT_PHASE,
    OP_NEXT_DIGIT,
    OP_EMIT
  } op_t;

  // Branch conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_CMD,
    C_DIV_MORE,
    C_SPACE_END,
    C_PHASE_END,
    C_OUT_BUSY
  } cond_t;

  // Program steps
  typedef enum logic [3:0] {
    S_WAIT,
    S_BRANCH,
    S_TICK,
    S_CONV_INIT,
    S_DIV,
    S_REM,
    S_LOAD,
    S_CHECK,
    S_STEP,
    S_NEXT_DIGIT,
    S_EMIT
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic cmd;
    logic div_more;
    logic space_end;
    logic phase_end;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ----- design/dgb_in_if.sv -----
// Input channel of the decimal digit blinker: valid/ready plus cmd and number.
// Depends on dgb_pkg for field widths.
`default_nettype none

interface dgb_in_if
  import dgb_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [NUM_W-1:0] number;

  modport source (output valid, output cmd, output number, input ready);
  modport sink   (input valid, input cmd, input number, output ready);
endinterface

`default_nettype wire

// ----- design/dgb_out_if.sv -----
// Result channel of the decimal digit blinker: valid/ready plus led_level and busy_res.
// Depends on dgb_pkg for field widths.
`default_nettype none

interface dgb_out_if
  import dgb_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] led_level;
  logic               busy_res;

  modport source (output valid, output led_level, output busy_res, input ready);
  modport sink   (input valid, input led_level, input busy_res, output ready);
endinterface

`default_nettype wire

// ----- design/dgb_sequencer.sv -----
// Microcode sequencer: step counter, program ROM and branch condition select.
// Depends on dgb_pkg.
`default_nettype none

module dgb_sequencer
  import dgb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  step_t pc;
  step_t pc_next;
  logic  take;

  // Program ROM: one control word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      S_WAIT:       w = '{OP_ACCEPT,     C_NO_INPUT,  S_WAIT,       S_BRANCH};
      S_BRANCH:     w = '{OP_NOP,        C_CMD,       S_CONV_INIT,  S_TICK};
      S_TICK:       w = '{OP_TICK,       C_ALWAYS,    S_CHECK,      S_CHECK};
      S_CONV_INIT:  w = '{OP_CONV_INIT,  C_ALWAYS,    S_DIV,        S_DIV};
      S_DIV:        w = '{OP_DIV,        C_ALWAYS,    S_REM,        S_REM};
      S_REM:        w = '{OP_REM,        C_DIV_MORE,  S_DIV,        S_LOAD};
      S_LOAD:       w = '{OP_LOAD,       C_ALWAYS,    S_CHECK,      S_CHECK};
      S_CHECK:      w = '{OP_NOP,        C_SPACE_END, S_NEXT_DIGIT, S_STEP};
      S_STEP:       w = '{OP_NEXT_PHASE, C_PHASE_END, S_CHECK,      S_EMIT};
      S_NEXT_DIGIT: w = '{OP_NEXT_DIGIT, C_ALWAYS,    S_LOAD,       S_LOAD};
      S_EMIT:       w = '{OP_EMIT,       C_OUT_BUSY,  S_EMIT,       S_WAIT};
      default:      w = '{OP_NOP,        C_ALWAYS,    S_WAIT,       S_WAIT};
    endcase
    return w;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    ctrl = ucode(pc);
    case (ctrl.cond)
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !status.in_valid;
      C_CMD:       take = status.cmd;
      C_DIV_MORE:  take = status.div_more;
      C_SPACE_END: take = status.space_end;
      C_PHASE_END: take = status.phase_end;
      C_OUT_BUSY:  take = status.out_busy;
      default:     take = 1'b1;
    endcase
    pc_next = take ? ctrl.tgt_true : ctrl.tgt_false;
  end

endmodule

`default_nettype wire

// ----- design/dgb_datapath.sv -----
// Datapath: config registers, divide-by-ten digit split, blink phase state and
// the output register. Driven by control words from dgb_sequencer; uses dgb_pkg.
`default_nettype none

module dgb_datapath
  import dgb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire ctrl_t                ctrl,
  output status_t                   status,
  dgb_in_if.sink                    in_ch,
  dgb_out_if.source                 out_ch
);

  // Config
  logic [CFG_W-1:0] on_ticks;
  logic [CFG_W-1:0] off_ticks;
  logic [CFG_W-1:0] space_ticks;
  logic [CFG_W-1:0] brightness;

  // Conversion
  logic               cmd_reg;
  logic [NUM_W-1:0]   num_reg;
  logic [NUM_W-1:0]   quot;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

  // Readout
  logic [PTR_W-1:0]   digit_pointer;
  logic [BLINK_W-1:0] blinks_left;
  phase_t             phase;
  logic [TICK_W-1:0]  tick_count;

  // Output register
  logic               out_valid;
  logic [LEVEL_W-1:0] led_level;
  logic               busy_res;

  logic                       in_take;
  logic                       out_busy;
  logic [DIGIT_W-1:0]         cur_digit;
  logic [TICK_W-1:0]          phase_len;
  logic                       phase_end;
  logic [NUM_W+RECIP_W-1:0]   product;
  logic [NUM_W-1:0]           quot_calc;
  logic [NUM_W-1:0]           rem_full;
  logic [PTR_W-1:0]           ptr_dec;

  assign in_ch.ready = (ctrl.op == OP_ACCEPT);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_busy    = out_valid && !out_ch.ready;

  always_comb begin
    cur_digit = '0;
    if (digit_pointer < PTR_W'(MAX_DIGITS)) begin
      cur_digit = digit_store[digit_pointer[IDX_W-1:0]];
    end
    case (phase)
      PH_ON:    phase_len = (cur_digit == '0) ? ZERO_BLINK_TICKS : on_ticks;
      PH_OFF:   phase_len = off_ticks;
      PH_SPACE: phase_len = space_ticks;
      default:  phase_len = '0;
    endcase
    phase_end = (phase != PH_IDLE) && (tick_count >= phase_len);
  end

  // n / 10 by reciprocal; remainder from the registered quotient
  assign product   = {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, RECIP_10};
  assign quot_calc = NUM_W'(product[NUM_W+RECIP_W-1:RECIP_SHIFT]);
  assign rem_full  = num_reg - ((quot << 3) + (quot << 1));
  assign ptr_dec   = digit_pointer - 1'b1;

  always_comb begin
    status.in_valid  = in_ch.valid;
    status.cmd       = cmd_reg;
    status.div_more  = (quot != '0) && (digit_pointer > PTR_W'(1));
    status.space_end = (phase == PH_SPACE) && (tick_count >= phase_len);
    status.phase_end = phase_end;
    status.out_busy  = out_busy;
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks    <= ON_TICKS_RST;
      off_ticks   <= OFF_TICKS_RST;
      space_ticks <= SPACE_TICKS_RST;
      brightness  <= BRIGHTNESS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ON_TICKS:    on_ticks    <= cfg_data;
        CFG_OFF_TICKS:   off_ticks   <= cfg_data;
        CFG_SPACE_TICKS: space_ticks <= cfg_data;
        CFG_BRIGHTNESS:  brightness  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_reg <= in_ch.cmd;
      num_reg <= in_ch.number;
    end else if (ctrl.op == OP_REM) begin
      num_reg <= quot;
    end
    if (ctrl.op == OP_DIV) begin
      quot <= quot_calc;
    end
    if (ctrl.op == OP_REM) begin
      digit_store[ptr_dec[IDX_W-1:0]] <= rem_full[DIGIT_W-1:0];
    end
  end

  // Readout state
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pointer <= PTR_W'(MAX_DIGITS);
      blinks_left   <= '0;
      phase         <= PH_IDLE;
      tick_count    <= '0;
    end else begin
      case (ctrl.op)
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            tick_count <= tick_count + 1'b1;
          end
        end
        OP_CONV_INIT: begin
          digit_pointer <= PTR_W'(MAX_DIGITS);
        end
        OP_REM: begin
          digit_pointer <= ptr_dec;
        end
        OP_LOAD: begin
          tick_count <= '0;
          if (digit_pointer >= PTR_W'(MAX_DIGITS)) begin
            digit_pointer <= PTR_W'(MAX_DIGITS);
            blinks_left   <= '0;
            phase         <= PH_IDLE;
          end else begin
            blinks_left <= (cur_digit == '0) ? '0 : BLINK_W'(cur_digit - 1'b1);
            phase       <= PH_ON;
          end
        end
        OP_NEXT_PHASE: begin
          if (phase_end) begin
            tick_count <= '0;
            if (phase == PH_ON) begin
              phase <= PH_OFF;
            end else if (phase == PH_OFF) begin
              if (blinks_left != '0) begin
                blinks_left <= blinks_left - 1'b1;
                phase       <= PH_ON;
              end else begin
                phase <= PH_SPACE;
              end
            end
          end
        end
        OP_NEXT_DIGIT: begin
          digit_pointer <= digit_pointer + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      led_level <= (phase == PH_ON) ? brightness : '0;
      busy_res  <= (phase != PH_IDLE);
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.led_level = led_level;
  assign out_ch.busy_res  = busy_res;

endmodule

`default_nettype wire

// ----- design/decimal_digit_blinker_unit.sv -----
// Top level of the decimal digit blinker: sequencer plus datapath.
// Depends on dgb_pkg, dgb_in_if, dgb_out_if, dgb_sequencer, dgb_datapath.
//
// Usage
//   in_ch carries one transaction per item: cmd 0 is one time tick, cmd 1
//   starts a readout of number (a start during a readout restarts it).
//   out_ch returns one transaction per input: led_level (brightness while a
//   blink is lit, else 0) and busy_res (readout still running).
//   cfg_we/cfg_index/cfg_data write on_ticks, off_ticks, space_ticks and
//   brightness (index 0..3); write only while no transaction is in flight.
//   A change takes effect at once, also in the middle of a readout.
// Timing
//   A microcoded program steps the datapath, one control word per cycle.
//   Tick: accept, branch on cmd, count the tick, check the digit gap, step
//   the phase, emit; each phase that ends adds a check and a step (plus a
//   digit move and load when the gap ends). Start: accept, branch, reset
//   the digit pointer, one divide-by-ten (multiply, then remainder) per
//   digit, k = digits converted (k <= 5), load, then check, step and emit;
//   one item is handled at a time. in_ch.ready is high only while waiting
//   for input, from the cycle after a result is loaded, even if not yet taken.
// Reset
//   rst (synchronous) restores register defaults, goes idle, empties out_ch.
// Stall
//   A held result stays put; the next item's result waits in its final step
//   until the output register is free.
`default_nettype none

module decimal_digit_blinker_unit
  import dgb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  dgb_in_if.sink                    in_ch,
  dgb_out_if.source                 out_ch
);

  ctrl_t   ctrl;    // current control word
  status_t status;  // datapath flags for branching

  dgb_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  dgb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .status    (status),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ----- design/dgb_checker.sv -----
// Port-level checks for decimal_digit_blinker_unit, attached by bind.
// Depends on dgb_pkg for widths.
`default_nettype none

module dgb_checker
  import dgb_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [LEVEL_W-1:0] led_level,
  input wire logic               busy_res
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_level) && $stable(busy_res))
    else $error("result changed while stalled");

  // Dark whenever the readout is over
  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> led_level == '0)
    else $error("led lit while not busy");

  // One transaction in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken twice in a row");

  // Every result has an input behind it
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("result without input");

endmodule

bind decimal_digit_blinker_unit dgb_checker u_dgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .led_level (out_ch.led_level),
  .busy_res  (out_ch.busy_res)
);

`default_nettype wire
